@@ rtl/wrs_pkg.sv @@
// Package with shared constants, types and helper functions of the windowed retransmit sender.
`default_nettype none
package wrs_pkg;
	localparam int WINDOW_SLOTS = 8;
	localparam int AGE_BITS = 16;
	localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int IDX_W = $clog2(WINDOW_SLOTS + 1);
	localparam int ID_W = 32;
	localparam int ENTRY_W = ID_W + AGE_BITS;
	localparam int IN_TDATA_W = 72;
	localparam int OUT_TDATA_W = 48;

	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_WAIT_START = 3'd1,
		PH_DATA       = 3'd2,
		PH_WAIT_END   = 3'd3,
		PH_DONE       = 3'd4,
		PH_FAIL_START = 3'd5,
		PH_FAIL_DATA  = 3'd6,
		PH_FAIL_END   = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		T_NONE          = 3'd0,
		T_START         = 3'd1,
		T_CONFIRM_START = 3'd2,
		T_DATA          = 3'd3,
		T_CONFIRM_DATA  = 3'd4,
		T_END           = 3'd5,
		T_CONFIRM_END   = 3'd6
	} msg_t;

	localparam logic [2:0] ACT_START = 3'd0;
	localparam logic [2:0] ACT_TICK = 3'd1;
	localparam logic [2:0] ACT_HEADER = 3'd2;
	localparam logic [2:0] ACT_CHUNK = 3'd3;
	localparam logic [2:0] ACT_END = 3'd4;

	localparam logic [1:0] CFG_CONN = 2'd0;
	localparam logic [1:0] CFG_IDLE = 2'd1;
	localparam logic [1:0] CFG_RETX = 2'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_START = 2'd1;
	localparam logic [1:0] ERR_DATA = 2'd2;
	localparam logic [1:0] ERR_END = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TRD,
		S_TEX,
		S_HRD,
		S_HEX,
		S_HEND,
		S_SEND,
		S_STATUS
	} state_t;

	function automatic logic [AGE_BITS-1:0] age_up(input logic [AGE_BITS-1:0] a);
		return (a == AGE_MAX) ? a : a + 1'b1;
	endfunction

	function automatic logic age_expired(input logic [AGE_BITS-1:0] a, input logic [15:0] rt);
		logic [31:0] ax;
		logic [31:0] rx;
		ax = 32'(a);
		rx = 32'(rt);
		return (ax >= rx) || (a == AGE_MAX);
	endfunction
endpackage
`default_nettype wire

@@ rtl/wrs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module wrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/windowed_retransmit_sender_core.sv @@
// Top level of the windowed retransmit sender: control sequencer, window memory and output stage.
// An item is taken only in the idle state; the next item waits until the status result of the
// last one has been loaded, and output stalls hold the block where it waits to load a result.
// A data-phase tick walks all slots through the slot memory, a read step per slot and a
// modify-and-write-back step per valid slot, then gives its status result; a data confirmation
// walks the same way but stops at the matching slot. Reset: arst_n asynchronously clears
// phase, counters, valid bits and the output valid, and sets the configuration registers
// to their defaults.
`default_nettype none
module windowed_retransmit_sender_core
	import wrs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [31:0]            cfg_wdata,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// tdata from bit 0: msg_ok(1), msg_type(3), msg_connection(32), msg_packet_id(32), zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// tuser: action(3)
	input  wire logic [2:0]             s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// tdata from bit 0: send_valid(1), send_type(3), send_packet_id(32), send_slot(3),
	// want_data(1), done_res(1), error_code(2), zero pad
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	output logic                        m_tlast
);
	// Configuration registers.
	logic [31:0] conn_id_q;
	logic [31:0] idle_limit_q;
	logic [15:0] retx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_id_q <= 32'd1;
			idle_limit_q <= 32'd10000;
			retx_q <= 16'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CONN: conn_id_q <= cfg_wdata;
				CFG_IDLE: idle_limit_q <= cfg_wdata;
				CFG_RETX: retx_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Input fields.
	logic        in_ok;
	logic [2:0]  in_type;
	logic [31:0] in_conn;
	logic [31:0] in_id;
	assign in_ok = s_tdata[0];
	assign in_type = s_tdata[3:1];
	assign in_conn = s_tdata[35:4];
	assign in_id = s_tdata[67:36];

	// Transfer state. The valid bits live in flip-flops; packet ids and ages of the slots
	// live in the slot memory and are only read while the slot is valid.
	state_t                  state_q, state_d;
	phase_t                  phase_q, phase_d;
	logic [31:0]             npn_q, npn_d;
	logic                    ie_q, ie_d;
	logic [31:0]             idle_q, idle_d;
	logic [AGE_BITS-1:0]     cage_q, cage_d;
	logic [WINDOW_SLOTS-1:0] valid_q, valid_d;
	logic [IDX_W-1:0]        idx_q, idx_d;
	logic [31:0]             mid_q, mid_d;
	logic [2:0]              pt_q, pt_d;
	logic [31:0]             pid_q, pid_d;
	logic [SLOT_W-1:0]       pslot_q, pslot_d;

	// Output stage.
	logic                    ov_q;
	logic [OUT_TDATA_W-1:0]  od_q;
	logic                    ol_q;
	logic                    out_free;
	logic                    out_load;
	logic [OUT_TDATA_W-1:0]  out_data;
	logic                    out_last;

	// Slot memory port.
	logic                    ram_we;
	logic [SLOT_W-1:0]       ram_waddr;
	logic [ENTRY_W-1:0]      ram_wdata;
	logic                    ram_re;
	logic [ENTRY_W-1:0]      ram_rdata;
	logic [ID_W-1:0]         rd_id;
	logic [AGE_BITS-1:0]     rd_age;
	logic [AGE_BITS-1:0]     rd_age_up;

	assign rd_id = ram_rdata[ID_W-1:0];
	assign rd_age = ram_rdata[ENTRY_W-1:ID_W];
	assign rd_age_up = age_up(rd_age);

	wrs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(WINDOW_SLOTS)
	) u_slot_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(idx_q[SLOT_W-1:0]),
		.rdata(ram_rdata)
	);

	// Status fields always reflect the registered state, which is already updated when a
	// send is loaded, so every result of an item carries the state after that item.
	logic       st_want;
	logic       st_done;
	logic [1:0] st_err;
	assign st_want = (phase_q == PH_DATA) && !ie_q && !(&valid_q);
	assign st_done = (phase_q == PH_DONE);
	always_comb begin
		unique case (phase_q)
			PH_FAIL_START: st_err = ERR_START;
			PH_FAIL_DATA: st_err = ERR_DATA;
			PH_FAIL_END: st_err = ERR_END;
			default: st_err = ERR_NONE;
		endcase
	end

	function automatic logic [OUT_TDATA_W-1:0] pack_out(
		input logic sv, input logic [2:0] ty, input logic [31:0] id,
		input logic [SLOT_W-1:0] sl, input logic w, input logic dn, input logic [1:0] er);
		logic [OUT_TDATA_W-1:0] r;
		r = '0;
		r[0] = sv;
		r[3:1] = ty;
		r[35:4] = id;
		r[38:36] = 3'(sl);
		r[39] = w;
		r[40] = dn;
		r[42:41] = er;
		return r;
	endfunction

	// Helpers computed from registered state.
	logic [31:0]         idle_inc;
	logic                idle_fail;
	logic [AGE_BITS-1:0] cage_inc;
	logic [SLOT_W-1:0]   free_idx;
	logic                accept;

	assign idle_inc = (idle_q == 32'hFFFF_FFFF) ? idle_q : idle_q + 32'd1;
	assign idle_fail = (idle_inc >= idle_limit_q);
	assign cage_inc = age_up(cage_q);
	assign accept = s_tvalid && s_tready;
	assign out_free = !ov_q || m_tready;

	always_comb begin
		free_idx = '0;
		for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		npn_d = npn_q;
		ie_d = ie_q;
		idle_d = idle_q;
		cage_d = cage_q;
		valid_d = valid_q;
		idx_d = idx_q;
		mid_d = mid_q;
		pt_d = pt_q;
		pid_d = pid_q;
		pslot_d = pslot_q;
		s_tready = 1'b0;
		ram_we = 1'b0;
		ram_waddr = idx_q[SLOT_W-1:0];
		ram_wdata = {rd_age_up, rd_id};
		ram_re = 1'b0;
		out_load = 1'b0;
		out_data = pack_out(1'b0, T_NONE, 32'd0, '0, st_want, st_done, st_err);
		out_last = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_STATUS;
					idx_d = '0;
					mid_d = in_id;
					pslot_d = '0;
					case (s_tuser)
						ACT_START: begin
							if (phase_q == PH_IDLE || phase_q >= PH_DONE) begin
								npn_d = '0;
								ie_d = 1'b0;
								idle_d = '0;
								cage_d = '0;
								valid_d = '0;
								phase_d = PH_WAIT_START;
								pt_d = T_START;
								pid_d = '0;
								state_d = S_SEND;
							end
						end
						ACT_TICK: begin
							if (phase_q == PH_WAIT_START || phase_q == PH_DATA ||
							    phase_q == PH_WAIT_END) begin
								idle_d = idle_inc;
								if (idle_fail) begin
									phase_d = phase_t'(phase_q + 3'd4);
								end else if (phase_q == PH_DATA) begin
									state_d = S_TRD;
								end else if (age_expired(cage_inc, retx_q)) begin
									cage_d = '0;
									pt_d = (phase_q == PH_WAIT_START) ? T_START : T_END;
									pid_d = (phase_q == PH_WAIT_START) ? 32'd0 : npn_q;
									state_d = S_SEND;
								end else begin
									cage_d = cage_inc;
								end
							end
						end
						ACT_HEADER: begin
							if (in_ok && in_conn == conn_id_q) begin
								if (phase_q == PH_WAIT_START && in_type == T_CONFIRM_START) begin
									idle_d = '0;
									if (ie_q) begin
										phase_d = PH_WAIT_END;
										cage_d = '0;
										pt_d = T_END;
										pid_d = npn_q;
										state_d = S_SEND;
									end else begin
										phase_d = PH_DATA;
									end
								end else if (phase_q == PH_DATA &&
								             in_type == T_CONFIRM_DATA) begin
									state_d = S_HRD;
								end else if (phase_q == PH_WAIT_END &&
								             in_type == T_CONFIRM_END && in_id == npn_q) begin
									phase_d = PH_DONE;
									idle_d = '0;
								end
							end
						end
						ACT_CHUNK: begin
							if (phase_q == PH_DATA && !ie_q && !(&valid_q)) begin
								valid_d[free_idx] = 1'b1;
								ram_we = 1'b1;
								ram_waddr = free_idx;
								ram_wdata = {{AGE_BITS{1'b0}}, npn_q};
								pt_d = T_DATA;
								pid_d = npn_q;
								pslot_d = free_idx;
								npn_d = npn_q + 32'd1;
								state_d = S_SEND;
							end
						end
						ACT_END: begin
							if (phase_q == PH_WAIT_START) begin
								ie_d = 1'b1;
							end else if (phase_q == PH_DATA) begin
								ie_d = 1'b1;
								if (~|valid_q) begin
									phase_d = PH_WAIT_END;
									cage_d = '0;
									pt_d = T_END;
									pid_d = npn_q;
									state_d = S_SEND;
								end
							end
						end
						default: ;
					endcase
				end
			end
			S_TRD: begin
				if (idx_q == IDX_W'(WINDOW_SLOTS)) begin
					state_d = S_STATUS;
				end else if (valid_q[idx_q[SLOT_W-1:0]]) begin
					ram_re = 1'b1;
					state_d = S_TEX;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_TEX: begin
				if (age_expired(rd_age_up, retx_q)) begin
					if (out_free) begin
						ram_we = 1'b1;
						ram_wdata = {{AGE_BITS{1'b0}}, rd_id};
						out_load = 1'b1;
						out_last = 1'b0;
						out_data = pack_out(1'b1, T_DATA, rd_id, idx_q[SLOT_W-1:0],
						                    st_want, st_done, st_err);
						idx_d = idx_q + 1'b1;
						state_d = S_TRD;
					end
				end else begin
					ram_we = 1'b1;
					idx_d = idx_q + 1'b1;
					state_d = S_TRD;
				end
			end
			S_HRD: begin
				if (idx_q == IDX_W'(WINDOW_SLOTS)) begin
					state_d = S_HEND;
				end else if (valid_q[idx_q[SLOT_W-1:0]]) begin
					ram_re = 1'b1;
					state_d = S_HEX;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_HEX: begin
				if (rd_id == mid_q) begin
					valid_d[idx_q[SLOT_W-1:0]] = 1'b0;
					idle_d = '0;
					state_d = S_HEND;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = S_HRD;
				end
			end
			S_HEND: begin
				if (ie_q && ~|valid_q) begin
					phase_d = PH_WAIT_END;
					cage_d = '0;
					pt_d = T_END;
					pid_d = npn_q;
					pslot_d = '0;
					state_d = S_SEND;
				end else begin
					state_d = S_STATUS;
				end
			end
			S_SEND: begin
				if (out_free) begin
					out_load = 1'b1;
					out_last = 1'b0;
					out_data = pack_out(1'b1, pt_q, pid_q, pslot_q, st_want, st_done, st_err);
					state_d = S_STATUS;
				end
			end
			S_STATUS: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_IDLE;
			npn_q <= '0;
			ie_q <= 1'b0;
			idle_q <= '0;
			cage_q <= '0;
			valid_q <= '0;
			idx_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			npn_q <= npn_d;
			ie_q <= ie_d;
			idle_q <= idle_d;
			cage_q <= cage_d;
			valid_q <= valid_d;
			idx_q <= idx_d;
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		mid_q <= mid_d;
		pt_q <= pt_d;
		pid_q <= pid_d;
		pslot_q <= pslot_d;
		if (out_load) begin
			od_q <= out_data;
			ol_q <= out_last;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata = od_q;
	assign m_tlast = ol_q;

	// A result without a send is always the closing result of its item.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !od_q[0]) |-> ol_q)
		else $error("status result without last");

	// A slot is only read back for modification while it is valid.
	a_tex_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TEX || state_q == S_HEX) |-> valid_q[idx_q[SLOT_W-1:0]])
		else $error("walk touched an invalid slot");

	// A transfer of an item always starts a sequence that leaves the idle state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("item accepted without processing");

	// Slots are only occupied during the data phase or once it has failed.
	a_slots_data: assert property (@(posedge clk) disable iff (!arst_n)
		(|valid_q) |-> (phase_q == PH_DATA || phase_q == PH_FAIL_DATA))
		else $error("window slots held outside the data phase");
endmodule
`default_nettype wire

@@ sim/tb_windowed_retransmit_sender_core.sv @@
// Testbench for the windowed retransmit sender core: predictor, scoreboard and stimulus.
`default_nettype none
module tb_windowed_retransmit_sender_core;
	import wrs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any transfer before the run is declared hung.
	localparam int HANG_LIMIT = 2000;
	// Cycles allowed for a slot walk to finish after its last result.
	localparam int SETTLE_CYCLES = 40;

	// The scoreboard carries its own copy of the sender's state and predicts every
	// result of each accepted item. Expected results are kept as {last, tdata[42:0]}.
	class wrs_scoreboard;
		logic [31:0] conn_id = 32'd1;
		logic [31:0] idle_limit = 32'd10000;
		logic [15:0] retx_ticks = 16'd100;
		phase_t      ph = PH_IDLE;
		logic [31:0] next_pn = '0;
		bit          ended = 0;
		logic [31:0] idle_cnt = '0;
		logic [15:0] ctrl_age = '0;
		bit          vld [WINDOW_SLOTS];
		logic [31:0] pn [WINDOW_SLOTS];
		logic [15:0] age [WINDOW_SLOTS];
		logic [38:0] sends [$];
		logic [43:0] pending [$];
		int          fails = 0;

		function logic [15:0] bump(logic [15:0] a);
			return (a == 16'hFFFF) ? a : a + 16'd1;
		endfunction

		function bit expired(logic [15:0] a);
			return (a >= retx_ticks) || (a == 16'hFFFF);
		endfunction

		// Counts one idle tick and tells whether the limit has been reached.
		function bit idle_hit();
			if (idle_cnt != 32'hFFFFFFFF)
				idle_cnt++;
			return idle_cnt >= idle_limit;
		endfunction

		function int first_free();
			for (int i = 0; i < WINDOW_SLOTS; i++)
				if (!vld[i])
					return i;
			return -1;
		endfunction

		function void push_send(msg_t ty, logic [31:0] id, int slot);
			logic [2:0] s3;
			s3 = slot[2:0];
			sends.push_back({s3, id, ty, 1'b1});
		endfunction

		function void clear_transfer();
			next_pn = '0;
			ended = 0;
			idle_cnt = '0;
			ctrl_age = '0;
			for (int i = 0; i < WINDOW_SLOTS; i++) begin
				vld[i] = 0;
				pn[i] = '0;
				age[i] = '0;
			end
		endfunction

		// END goes out once input has ended and every DATA has been confirmed.
		function void try_end();
			if (ph == PH_DATA && ended && first_free() == 0 && !vld[WINDOW_SLOTS-1]) begin
				bit empty;
				empty = 1;
				for (int i = 0; i < WINDOW_SLOTS; i++)
					if (vld[i])
						empty = 0;
				if (empty) begin
					push_send(T_END, next_pn, 0);
					ph = PH_WAIT_END;
					ctrl_age = '0;
				end
			end
		endfunction

		function void on_tick();
			if (ph == PH_WAIT_START || ph == PH_WAIT_END) begin
				if (idle_hit()) begin
					ph = (ph == PH_WAIT_START) ? PH_FAIL_START : PH_FAIL_END;
					return;
				end
				ctrl_age = bump(ctrl_age);
				if (expired(ctrl_age)) begin
					if (ph == PH_WAIT_START)
						push_send(T_START, '0, 0);
					else
						push_send(T_END, next_pn, 0);
					ctrl_age = '0;
				end
			end else if (ph == PH_DATA) begin
				if (idle_hit()) begin
					ph = PH_FAIL_DATA;
					return;
				end
				for (int i = 0; i < WINDOW_SLOTS; i++) begin
					if (vld[i]) begin
						age[i] = bump(age[i]);
						if (expired(age[i])) begin
							push_send(T_DATA, pn[i], i);
							age[i] = '0;
						end
					end
				end
			end
		endfunction

		function void on_header(logic ok, logic [2:0] ty, logic [31:0] conn, logic [31:0] id);
			if (!ok || conn != conn_id)
				return;
			if (ph == PH_WAIT_START && ty == T_CONFIRM_START) begin
				ph = PH_DATA;
				idle_cnt = '0;
				try_end();
			end else if (ph == PH_DATA && ty == T_CONFIRM_DATA) begin
				for (int i = 0; i < WINDOW_SLOTS; i++) begin
					if (vld[i] && pn[i] == id) begin
						vld[i] = 0;
						idle_cnt = '0;
						break;
					end
				end
				try_end();
			end else if (ph == PH_WAIT_END && ty == T_CONFIRM_END && id == next_pn) begin
				ph = PH_DONE;
				idle_cnt = '0;
			end
		endfunction

		// Notes one accepted input transfer and queues the results it must cause.
		function void note_input(logic [2:0] act, logic ok, logic [2:0] ty,
				logic [31:0] conn, logic [31:0] id);
			int s;
			bit want;
			bit fin;
			logic [1:0] err;
			sends.delete();
			case (act)
				ACT_START: begin
					if (ph == PH_IDLE || ph >= PH_DONE) begin
						clear_transfer();
						push_send(T_START, '0, 0);
						ph = PH_WAIT_START;
					end
				end
				ACT_TICK: on_tick();
				ACT_HEADER: on_header(ok, ty, conn, id);
				ACT_CHUNK: begin
					if (ph == PH_DATA && !ended) begin
						s = first_free();
						if (s >= 0) begin
							vld[s] = 1;
							pn[s] = next_pn;
							age[s] = '0;
							push_send(T_DATA, next_pn, s);
							next_pn++;
						end
					end
				end
				ACT_END: begin
					if (ph == PH_WAIT_START || ph == PH_DATA) begin
						ended = 1;
						try_end();
					end
				end
				default: ;
			endcase
			sends.push_back('0);
			want = (ph == PH_DATA) && !ended && (first_free() >= 0);
			fin = (ph == PH_DONE);
			case (ph)
				PH_FAIL_START: err = ERR_START;
				PH_FAIL_DATA: err = ERR_DATA;
				PH_FAIL_END: err = ERR_END;
				default: err = ERR_NONE;
			endcase
			foreach (sends[k])
				pending.push_back({k == sends.size() - 1, err, fin, want, sends[k]});
		endfunction

		// Compares one accepted output transfer with the oldest expectation.
		function void check_result(logic [42:0] d, logic l);
			logic [43:0] e;
			if (pending.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result tdata=%h last=%b", d, l);
				return;
			end
			e = pending.pop_front();
			if ({l, d} !== e) begin
				fails++;
				if (fails <= 10)
					$display({"mismatch: send_valid %b/%b type %0d/%0d id %h/%h slot %0d/%0d ",
						"want %b/%b done %b/%b err %0d/%0d last %b/%b (expected/actual)"},
						e[0], d[0], e[3:1], d[3:1], e[35:4], d[35:4], e[38:36], d[38:36],
						e[39], d[39], e[40], d[40], e[42:41], d[42:41], e[43], l);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic [2:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tlast;

	wrs_scoreboard sb;
	int items_sent = 0;
	int hang_cnt = 0;
	// When set, both sides run without gaps for a while.
	bit no_gaps = 0;

	windowed_retransmit_sender_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Watchdog: any transfer on either side restarts the count.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			hang_cnt <= 0;
		else
			hang_cnt <= hang_cnt + 1;
		if (hang_cnt >= HANG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offers one input item after a random gap and waits for its transfer. The valid
	// stays high when the next item follows without a gap.
	task automatic send_item(logic [2:0] act, logic ok, logic [2:0] ty,
			logic [31:0] conn, logic [31:0] id);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {4'b0, id, conn, ty, ok};
		do @(posedge clk); while (!s_tready);
		sb.note_input(act, ok, ty, conn, id);
		items_sent++;
	endtask

	task automatic do_action(logic [2:0] act);
		send_item(act, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 6)), $urandom,
			$urandom);
	endtask

	// A well-formed header on the configured connection.
	task automatic header(msg_t ty, logic [31:0] id);
		send_item(ACT_HEADER, 1'b1, ty, sb.conn_id, id);
	endtask

	// Confirms one outstanding DATA packet, if there is any, and else sends a tick.
	task automatic ack_outstanding();
		int picks [$];
		for (int i = 0; i < WINDOW_SLOTS; i++)
			if (sb.vld[i])
				picks.push_back(i);
		if (picks.size() > 0)
			header(T_CONFIRM_DATA, sb.pn[picks[$urandom_range(0, picks.size() - 1)]]);
		else
			do_action(ACT_TICK);
	endtask

	// Random junk: any action, header fields that may or may not pass.
	task automatic noise_item();
		logic [31:0] conn;
		conn = ($urandom_range(0, 1) == 1) ? sb.conn_id : $urandom;
		send_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
			3'($urandom_range(0, 6)), conn, $urandom);
	endtask

	// Withdraws the input, then waits until every expected result has arrived and any
	// slot walk has ended.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all three registers on successive edges; only while the block is idle.
	task automatic write_regs(logic [31:0] conn, logic [31:0] idle_lim, logic [15:0] retx);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CONN;
		cfg_wdata <= conn;
		@(posedge clk);
		cfg_index <= CFG_IDLE;
		cfg_wdata <= idle_lim;
		@(posedge clk);
		cfg_index <= CFG_RETX;
		cfg_wdata <= {16'h0, retx};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.conn_id = conn;
		sb.idle_limit = idle_lim;
		sb.retx_ticks = retx;
	endtask

	// One transfer: start, confirmation, a random mix of chunks, ticks and acks,
	// end of input, remaining acks and the END handshake, with noise sprinkled in.
	task automatic run_transfer();
		int chunks;
		int steps;
		chunks = $urandom_range(1, 14);
		send_item(ACT_START, 0, 0, 0, 0);
		repeat ($urandom_range(0, 3)) do_action(ACT_TICK);
		if ($urandom_range(0, 5) == 0)
			do_action(ACT_END);
		header(T_CONFIRM_START, $urandom);
		steps = 0;
		while (sb.ph == PH_DATA && !sb.ended && steps < 40) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					if (chunks > 0) begin
						do_action(ACT_CHUNK);
						chunks--;
					end else begin
						do_action(ACT_END);
					end
				end
				4, 5: ack_outstanding();
				6, 7: do_action(ACT_TICK);
				8: noise_item();
				default: header(T_CONFIRM_DATA, $urandom_range(0, 20));
			endcase
			steps++;
		end
		if (sb.ph == PH_DATA && !sb.ended)
			do_action(ACT_END);
		steps = 0;
		while (sb.ph == PH_DATA && steps < 30) begin
			if ($urandom_range(0, 2) == 0)
				do_action(ACT_TICK);
			else
				ack_outstanding();
			steps++;
		end
		if (sb.ph == PH_WAIT_END) begin
			repeat ($urandom_range(0, 3)) do_action(ACT_TICK);
			if ($urandom_range(0, 2) == 0)
				header(T_CONFIRM_END, sb.next_pn + 1);
			header(T_CONFIRM_END, sb.next_pn);
		end
		if ($urandom_range(0, 3) == 0)
			noise_item();
	endtask

	// Receiver: stalls a random number of cycles before each result.
	initial begin
		int gap;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata[42:0], m_tlast);
		end
	end

	initial begin
		logic [31:0] conn;
		logic [31:0] idle_lim;
		logic [15:0] retx;
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_CONN;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_TICK;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Short timeouts and a retransmit every tick make the
		// special cases show up within a few items.
		write_regs(32'h0000_0005, 32'd4, 16'd1);
		do_action(3'd5);
		do_action(3'd6);
		do_action(3'd7);
		do_action(ACT_TICK);
		do_action(ACT_CHUNK);
		do_action(ACT_END);
		send_item(ACT_START, 0, 0, 0, 0);
		// A start while a transfer is busy is ignored; an early end is remembered.
		send_item(ACT_START, 0, 0, 0, 0);
		do_action(ACT_END);
		do_action(ACT_TICK);
		send_item(ACT_HEADER, 1'b0, T_CONFIRM_START, 32'h5, 32'h0);
		send_item(ACT_HEADER, 1'b1, T_CONFIRM_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		header(T_CONFIRM_DATA, 32'h0);
		// The confirmation sends END right away, then a wrong and a right END ack.
		header(T_CONFIRM_START, 32'h0);
		header(T_CONFIRM_END, 32'h1);
		header(T_CONFIRM_END, 32'h0);
		send_item(ACT_START, 0, 0, 0, 0);
		repeat (4) do_action(ACT_TICK);
		drain();

		// Full window, then a tick at the largest age limit, confirmations and a chunk into the freed slot.
		write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(ACT_START, 0, 0, 0, 0);
		header(T_CONFIRM_START, 32'h0);
		no_gaps = 1;
		repeat (9) do_action(ACT_CHUNK);
		no_gaps = 0;
		do_action(ACT_TICK);
		header(T_CONFIRM_DATA, 32'd3);
		header(T_CONFIRM_DATA, 32'hFFFF_FFFF);
		do_action(ACT_CHUNK);
		drain();

		// Random part: a new register setting before each transfer.
		while (items_sent < 300) begin
			case ($urandom_range(0, 3))
				0: conn = 32'h1;
				1: conn = 32'hFFFF_FFFF;
				default: conn = $urandom_range(1, 32'hFFFF_FFFF);
			endcase
			case ($urandom_range(0, 4))
				0: idle_lim = 32'd1;
				1: idle_lim = 32'hFFFF_FFFF;
				2: idle_lim = 32'd10000;
				default: idle_lim = $urandom_range(2, 40);
			endcase
			case ($urandom_range(0, 3))
				0: retx = 16'd1;
				1: retx = 16'hFFFF;
				default: retx = 16'($urandom_range(1, 6));
			endcase
			no_gaps = ($urandom_range(0, 4) == 0);
			write_regs(conn, idle_lim, retx);
			run_transfer();
			no_gaps = 0;
			drain();
		end
		drain();

		if (sb.fails == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/wrs_pkg.sv
rtl/wrs_ram.sv
rtl/windowed_retransmit_sender_core.sv
sim/tb_windowed_retransmit_sender_core.sv
